@@ src/fmva_pkg.sv @@
// Shared types and constants of the feature mean and variance accumulator.
`default_nettype none

package fmva_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 8;
    localparam int CNT_W      = 24;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 32;
    localparam int FLOOR_W    = 16;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 40;
    localparam int FRAC_W     = 16;
    localparam int SQ_SPLIT   = 20;
    localparam int PART_W     = CNT_W + SQ_SPLIT;
    localparam int PROD_W     = 2 * SUM_W;
    localparam int NN_W       = 2 * CNT_W;
    localparam int DIV_HI_W   = NN_W;
    localparam int DIV_LO_W   = VAR_W;
    localparam int DIV_CNT_W  = 6;
    localparam int IDX_CMP_W  = 17;

    localparam int DEF_FEATURES   = 1024;
    localparam int DEF_COUNT_BITS = 24;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd7864;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_VARIANCE_FLOOR = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_ACCUMULATE = 2'd1,
        CMD_QUERY      = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [SUM_W-1:0] sum;
    } t_entry;

    typedef struct packed {
        logic load;
        logic acc_wr;
        logic clr_wr;
        logic mul1;
        logic mul2;
        logic sum;
        logic diff;
        logic div_start;
        logic div_sel_var;
        logic mean_cap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ src/fmva_if.sv @@
// Command and result channel interfaces of the accumulator.
`default_nettype none

interface fmva_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [fmva_pkg::CMD_W-1:0]  command;
    logic [fmva_pkg::IDX_W-1:0]  feature_index;
    logic [fmva_pkg::VAL_W-1:0]  sample_value;
    logic [fmva_pkg::CNT_W-1:0]  sample_count;

    modport source (
        output valid, command, feature_index, sample_value, sample_count,
        input  ready
    );
    modport sink (
        input  valid, command, feature_index, sample_value, sample_count,
        output ready
    );
endinterface

interface fmva_res_if;
    logic                        valid;
    logic                        ready;
    logic [fmva_pkg::IDX_W-1:0]  result_index;
    logic [fmva_pkg::MEAN_W-1:0] mean_value;
    logic [fmva_pkg::VAR_W-1:0]  variance_value;
    logic                        count_error;

    modport source (
        output valid, result_index, mean_value, variance_value, count_error,
        input  ready
    );
    modport sink (
        input  valid, result_index, mean_value, variance_value, count_error,
        output ready
    );
endinterface

`default_nettype wire

@@ src/fmva_div.sv @@
// Bit-serial restoring divider with saturating quotient.
`default_nettype none

module fmva_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [fmva_pkg::DIV_HI_W-1:0]   i_num_hi,
    input  wire logic [fmva_pkg::DIV_LO_W-1:0]   i_num_lo,
    input  wire logic [fmva_pkg::DIV_HI_W-1:0]   i_den,
    input  wire logic [fmva_pkg::DIV_CNT_W-1:0]  i_iters,
    output      logic                            o_busy,
    output      logic [fmva_pkg::DIV_LO_W-1:0]   o_quot
);
    import fmva_pkg::*;

    localparam int SH_W = DIV_HI_W + 1;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_HI_W-1:0]  r_rem;
    logic [DIV_LO_W-1:0]  r_lo;
    logic [DIV_HI_W-1:0]  r_den;
    logic [DIV_LO_W-1:0]  r_q;
    logic                 r_sat;

    logic [SH_W-1:0]      w_shift;
    logic [SH_W:0]        w_diff;
    logic                 w_bit;
    logic [DIV_HI_W-1:0]  w_rem_next;

    assign w_shift    = {r_rem, r_lo[DIV_LO_W-1]};
    assign w_diff     = {1'b0, w_shift} - {2'b00, r_den};
    assign w_bit      = ~w_diff[SH_W];
    assign w_rem_next = w_bit ? w_diff[DIV_HI_W-1:0] : w_shift[DIV_HI_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_iters;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num_hi;
            r_lo  <= i_num_lo;
            r_den <= i_den;
            r_sat <= (i_num_hi >= i_den);
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_rem_next;
            r_lo  <= {r_lo[DIV_LO_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_LO_W-2:0], w_bit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_sat ? '1 : r_q;

endmodule

`default_nettype wire

@@ src/fmva_dpath.sv @@
// Datapath: sum memory, multipliers, difference and result registers.
`default_nettype none

module fmva_dpath #(
    parameter int FEATURES   = fmva_pkg::DEF_FEATURES,
    parameter int COUNT_BITS = fmva_pkg::DEF_COUNT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fmva_pkg::t_dp_cmd              i_cmd,
    output      fmva_pkg::t_dp_sts              o_sts,
    input  wire logic [fmva_pkg::IDX_W-1:0]     i_feature_index,
    input  wire logic [fmva_pkg::VAL_W-1:0]     i_sample_value,
    input  wire logic [fmva_pkg::CNT_W-1:0]     i_sample_count,
    input  wire logic [fmva_pkg::FLOOR_W-1:0]   i_floor,
    output      logic [fmva_pkg::IDX_W-1:0]     o_result_index,
    output      logic [fmva_pkg::MEAN_W-1:0]    o_mean_value,
    output      logic [fmva_pkg::VAR_W-1:0]     o_variance_value,
    output      logic                           o_count_error
);
    import fmva_pkg::*;

    localparam int AW       = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int NB       = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] N_MASK = CNT_W'((64'd1 << NB) - 64'd1);
    localparam int SUM_X_W  = SUM_W + 1;
    localparam int SQ_X_W   = SQ_W + 1;
    localparam int VSQ_W    = 2 * VAL_W;
    localparam int MEAN_SH  = MEAN_W - FRAC_W;
    localparam int VAR_X_W  = VAR_W + 1;

    t_entry               r_mem [FEATURES];
    t_entry               r_rd;
    logic [AW-1:0]        r_clr_addr;
    logic [IDX_W-1:0]     r_idx;
    logic [VAL_W-1:0]     r_val;
    logic [CNT_W-1:0]     r_n;
    logic                 r_inside;
    logic [PROD_W-1:0]    r_ss;
    logic [PART_W-1:0]    r_plo;
    logic [PART_W-1:0]    r_phi;
    logic [NN_W-1:0]      r_nn;
    logic [PROD_W-1:0]    r_a;
    logic [PROD_W-1:0]    r_d;
    logic [MEAN_W-1:0]    r_mean;
    logic [IDX_W-1:0]     r_out_idx;
    logic [MEAN_W-1:0]    r_out_mean;
    logic [VAR_W-1:0]     r_out_var;
    logic                 r_out_err;

    logic                 w_clr_last;
    logic [AW-1:0]        w_addr;
    logic [AW-1:0]        w_rd_addr;
    logic [VSQ_W-1:0]     w_val_sq;
    logic [SUM_X_W-1:0]   w_sum_add;
    logic [SQ_X_W-1:0]    w_sq_add;
    t_entry               w_acc_entry;
    logic [SUM_W-1:0]     w_s;
    logic [SQ_W-1:0]      w_sq;
    logic [PROD_W:0]      w_diff;
    logic [DIV_HI_W-1:0]  w_div_hi;
    logic [DIV_LO_W-1:0]  w_div_lo;
    logic [DIV_HI_W-1:0]  w_div_den;
    logic [DIV_CNT_W-1:0] w_div_iters;
    logic                 w_div_busy;
    logic [DIV_LO_W-1:0]  w_div_quot;
    logic [VAR_X_W-1:0]   w_var_sum;
    logic                 w_err;

    assign w_addr     = AW'(r_idx);
    assign w_rd_addr  = AW'(i_feature_index);
    assign w_clr_last = (r_clr_addr == AW'(FEATURES - 1));

    assign w_val_sq   = VSQ_W'(r_val) * VSQ_W'(r_val);
    assign w_sum_add  = SUM_X_W'(r_rd.sum) + SUM_X_W'(r_val);
    assign w_sq_add   = SQ_X_W'(r_rd.sq) + SQ_X_W'(w_val_sq);

    always_comb begin
        w_acc_entry.sum = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
        w_acc_entry.sq  = w_sq_add[SQ_W] ? '1 : w_sq_add[SQ_W-1:0];
    end

    assign w_s  = r_inside ? r_rd.sum : '0;
    assign w_sq = r_inside ? r_rd.sq : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.acc_wr && r_inside) begin
            r_mem[w_addr] <= w_acc_entry;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= w_clr_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx    <= i_feature_index;
            r_val    <= i_sample_value;
            r_n      <= i_sample_count & N_MASK;
            r_inside <= (IDX_CMP_W'(i_feature_index) < IDX_CMP_W'(FEATURES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_ss  <= PROD_W'(w_s) * PROD_W'(w_s);
            r_plo <= PART_W'(r_n) * PART_W'(w_sq[SQ_SPLIT-1:0]);
        end
        if (i_cmd.mul2) begin
            r_phi <= PART_W'(r_n) * PART_W'(w_sq[SQ_W-1:SQ_SPLIT]);
            r_nn  <= NN_W'(r_n) * NN_W'(r_n);
        end
        if (i_cmd.sum) begin
            r_a <= (PROD_W'(r_phi) << SQ_SPLIT) + PROD_W'(r_plo);
        end
        if (i_cmd.diff) begin
            r_d <= w_diff[PROD_W] ? '0 : w_diff[PROD_W-1:0];
        end
        if (i_cmd.mean_cap) begin
            r_mean <= w_div_quot[MEAN_W-1:0];
        end
    end

    assign w_diff = {1'b0, r_a} - {1'b0, r_ss};

    always_comb begin
        if (i_cmd.div_sel_var) begin
            w_div_hi    = r_d[PROD_W-1:FRAC_W];
            w_div_lo    = {r_d[FRAC_W-1:0], {(DIV_LO_W - FRAC_W){1'b0}}};
            w_div_den   = r_nn;
            w_div_iters = DIV_CNT_W'(VAR_W);
        end else begin
            w_div_hi    = DIV_HI_W'(w_s >> MEAN_SH);
            w_div_lo    = {w_s[MEAN_SH-1:0], {(DIV_LO_W - MEAN_SH){1'b0}}};
            w_div_den   = DIV_HI_W'(r_n);
            w_div_iters = DIV_CNT_W'(MEAN_W);
        end
    end

    fmva_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num_hi (w_div_hi),
        .i_num_lo (w_div_lo),
        .i_den    (w_div_den),
        .i_iters  (w_div_iters),
        .o_busy   (w_div_busy),
        .o_quot   (w_div_quot)
    );

    assign w_err     = (r_n == '0);
    assign w_var_sum = VAR_X_W'(w_div_quot) + VAR_X_W'(i_floor);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= r_idx;
            r_out_err  <= w_err;
            r_out_mean <= w_err ? '0 : r_mean;
            if (w_err) begin
                r_out_var <= '0;
            end else begin
                r_out_var <= w_var_sum[VAR_W] ? '1 : w_var_sum[VAR_W-1:0];
            end
        end
    end

    always_comb begin
        o_sts.clr_last = w_clr_last;
        o_sts.div_busy = w_div_busy;
    end

    assign o_result_index   = r_out_idx;
    assign o_mean_value     = r_out_mean;
    assign o_variance_value = r_out_var;
    assign o_count_error    = r_out_err;

endmodule

`default_nettype wire

@@ src/fmva_ctrl.sv @@
// Controller: command sequencing, clearing sweep and result handshake.
`default_nettype none

module fmva_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [fmva_pkg::CMD_W-1:0]  i_in_command,
    output      logic                        o_in_ready,
    input  wire logic                        i_out_ready,
    output      logic                        o_out_valid,
    output      fmva_pkg::t_dp_cmd           o_cmd,
    input  wire fmva_pkg::t_dp_sts           i_sts
);
    import fmva_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_ACC   = 9'b000000100,
        S_MUL1  = 9'b000001000,
        S_MUL2  = 9'b000010000,
        S_SUM   = 9'b000100000,
        S_DIFF  = 9'b001000000,
        S_MWAIT = 9'b010000000,
        S_VWAIT = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_cmd'(i_in_command))
                        CMD_CLEAR:      n_state = S_CLEAR;
                        CMD_ACCUMULATE: n_state = S_ACC;
                        CMD_QUERY:      n_state = S_MUL1;
                        default:        n_state = S_IDLE;
                    endcase
                end
            end
            S_ACC: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_MUL1: begin
                o_cmd.mul1      = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MWAIT;
            end
            S_MWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.mean_cap    = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_var = 1'b1;
                    n_state           = S_VWAIT;
                end
            end
            S_VWAIT: begin
                o_cmd.div_sel_var = 1'b1;
                if (!i_sts.div_busy && (!r_out_valid || i_out_ready)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ src/feature_mean_variance_accumulator.sv @@
// Top level of the per-feature running mean and variance accumulator.
//
// Keeps a running sum and sum of squares per feature in one 72-bit-wide memory of
// FEATURES entries. Commands are taken one at a time. An accumulate reads memory,
// then does a saturating write back. A query runs the shared bit-serial divider,
// which forms a 24-bit quotient for the mean and a 32-bit one for the variance,
// with the products formed while the mean divides; its result is loaded only once
// the divider is done and the previous result has been taken. A clear, and the
// pass that runs after reset, write zero to one entry a cycle over all FEATURES
// entries, no command accepted meanwhile (the variance_floor register stays
// writable). An unused command code gives no result.
`default_nettype none

module feature_mean_variance_accumulator #(
    parameter int FEATURES   = fmva_pkg::DEF_FEATURES,
    parameter int COUNT_BITS = fmva_pkg::DEF_COUNT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    fmva_cmd_if.sink                               i_cmd,
    fmva_res_if.source                             o_res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fmva_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [fmva_pkg::APB_DATA_W-1:0]   pwdata,
    output      logic [fmva_pkg::APB_DATA_W-1:0]   prdata,
    output      logic                              pready
);
    import fmva_pkg::*;

    logic [FLOOR_W-1:0] r_floor;
    logic               w_reg_hit;
    logic               w_in_ready;
    logic               w_out_valid;
    t_dp_cmd            w_cmd;
    t_dp_sts            w_sts;

    assign w_reg_hit = (paddr[APB_ADDR_W-1:2] == REG_VARIANCE_FLOOR);
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? APB_DATA_W'(r_floor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_floor <= pwdata[FLOOR_W-1:0];
        end
    end

    fmva_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .i_in_command (i_cmd.command),
        .o_in_ready   (w_in_ready),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (w_out_valid),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    fmva_dpath #(
        .FEATURES   (FEATURES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_feature_index  (i_cmd.feature_index),
        .i_sample_value   (i_cmd.sample_value),
        .i_sample_count   (i_cmd.sample_count),
        .i_floor          (r_floor),
        .o_result_index   (o_res.result_index),
        .o_mean_value     (o_res.mean_value),
        .o_variance_value (o_res.variance_value),
        .o_count_error    (o_res.count_error)
    );

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

endmodule

`default_nettype wire

@@ src/fmva_chk.sv @@
// Port-level assertions for the accumulator and their bind to the top level.
`default_nettype none

module fmva_chk (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [fmva_pkg::CMD_W-1:0]   i_in_command,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [fmva_pkg::IDX_W-1:0]   i_out_idx,
    input  wire logic [fmva_pkg::MEAN_W-1:0]  i_out_mean,
    input  wire logic [fmva_pkg::VAR_W-1:0]   i_out_var,
    input  wire logic                         i_out_err
);
    import fmva_pkg::*;

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready &&
        (i_in_command == CMD_CLEAR || i_in_command == CMD_ACCUMULATE ||
         i_in_command == CMD_QUERY)
        |=> !i_in_ready)
        else $error("input still ready after a command transaction");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a query in progress");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_err |-> (i_out_mean == '0) && (i_out_var == '0))
        else $error("count error with nonzero statistics");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable({i_out_idx, i_out_mean, i_out_var, i_out_err}))
        else $error("stalled result transaction changed");

endmodule

bind feature_mean_variance_accumulator fmva_chk u_fmva_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_in_command (i_cmd.command),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_idx    (o_res.result_index),
    .i_out_mean   (o_res.mean_value),
    .i_out_var    (o_res.variance_value),
    .i_out_err    (o_res.count_error)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the per-feature mean and variance accumulator.
`timescale 1ns / 1ps

module tb_top;
    import fmva_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] FLOOR_ADDR = {REG_VARIANCE_FLOOR, 2'b00};
    localparam int CLEAR_CYCLES = DEF_FEATURES + 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOT_COUNT    = 8;
    localparam int PAD_W        = APB_DATA_W - FLOOR_W;
    localparam int WIDE_W       = 128;
    localparam int SUM_X_W      = SUM_W + 1;
    localparam int SQ_X_W       = SQ_W + 1;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
        logic              count_err;
    } t_stats;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    fmva_cmd_if cmd_bus ();
    fmva_res_if res_bus ();

    feature_mean_variance_accumulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [SUM_W-1:0]   value_sum [DEF_FEATURES];
    logic [SQ_W-1:0]    square_sum [DEF_FEATURES];
    int                 samples_at [DEF_FEATURES];
    logic [FLOOR_W-1:0] floor_setting;
    t_stats             pending_stats [$];
    logic [IDX_W-1:0]   hot_idx [HOT_COUNT];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_request;
    int hold_served;
    int hold_left;
    int failures;
    int quiet_cycles;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_stats stats_from_sums(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cnt);
        logic [WIDE_W-1:0] n_w;
        logic [WIDE_W-1:0] s_w;
        logic [WIDE_W-1:0] sq_w;
        logic [WIDE_W-1:0] lhs;
        logic [WIDE_W-1:0] rhs;
        logic [WIDE_W-1:0] spread;
        logic [WIDE_W-1:0] m_w;
        logic [WIDE_W-1:0] v_w;
        t_stats r;
        r.index     = idx;
        r.mean      = '0;
        r.variance  = '0;
        r.count_err = 1'b0;
        if (cnt == '0) begin
            r.count_err = 1'b1;
        end else begin
            n_w    = WIDE_W'(cnt);
            s_w    = WIDE_W'(value_sum[idx]);
            sq_w   = WIDE_W'(square_sum[idx]);
            lhs    = n_w * sq_w;
            rhs    = s_w * s_w;
            spread = (lhs > rhs) ? lhs - rhs : '0;
            m_w    = (s_w << FRAC_W) / n_w;
            r.mean = (m_w > {MEAN_W{1'b1}}) ? {MEAN_W{1'b1}} : m_w[MEAN_W-1:0];
            v_w    = (spread << FRAC_W) / (n_w * n_w);
            if (v_w > {VAR_W{1'b1}}) v_w = {VAR_W{1'b1}};
            v_w = v_w + WIDE_W'(floor_setting);
            r.variance = (v_w > {VAR_W{1'b1}}) ? {VAR_W{1'b1}} : v_w[VAR_W-1:0];
        end
        return r;
    endfunction

    function automatic void fold_command(input logic [CMD_W-1:0] op,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W-1:0] val,
                                         input logic [CNT_W-1:0] cnt);
        logic [SUM_X_W-1:0] sum_ext;
        logic [SQ_X_W-1:0]  sq_ext;
        case (op)
            CMD_CLEAR: begin
                for (int i = 0; i < DEF_FEATURES; i++) begin
                    value_sum[i]  = '0;
                    square_sum[i] = '0;
                    samples_at[i] = 0;
                end
            end
            CMD_ACCUMULATE: begin
                sum_ext = SUM_X_W'(value_sum[idx]) + SUM_X_W'(val);
                sq_ext  = SQ_X_W'(square_sum[idx]) + SQ_X_W'(val) * SQ_X_W'(val);
                value_sum[idx]  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                square_sum[idx] = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
                samples_at[idx]++;
            end
            CMD_QUERY: pending_stats.push_back(stats_from_sums(idx, cnt));
            default: ;
        endcase
    endfunction

    function automatic void check_result();
        t_stats exp_s;
        if (pending_stats.size() == 0) begin
            $error("unexpected result transaction, index %0d", res_bus.result_index);
            failures++;
        end else begin
            exp_s = pending_stats.pop_front();
            if (res_bus.result_index !== exp_s.index) begin
                $error("result_index expected %0d actual %0d",
                       exp_s.index, res_bus.result_index);
                failures++;
            end
            if (res_bus.mean_value !== exp_s.mean) begin
                $error("mean_value expected %0h actual %0h",
                       exp_s.mean, res_bus.mean_value);
                failures++;
            end
            if (res_bus.variance_value !== exp_s.variance) begin
                $error("variance_value expected %0h actual %0h",
                       exp_s.variance, res_bus.variance_value);
                failures++;
            end
            if (res_bus.count_error !== exp_s.count_err) begin
                $error("count_error expected %0b actual %0b",
                       exp_s.count_err, res_bus.count_error);
                failures++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) check_result();
        if (hold_request != hold_served) begin
            hold_served   <= hold_request;
            hold_left     <= HOLD_CYCLES;
            res_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic [CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= op;
        cmd_bus.feature_index <= idx;
        cmd_bus.sample_value  <= val;
        cmd_bus.sample_count  <= cnt;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        fold_command(op, idx, val, cnt);
    endtask

    task automatic stop_sending();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        stop_sending();
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (CLEAR_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
    endtask

    task automatic program_floor(input logic [FLOOR_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_read(FLOOR_ADDR, rd);
        if (rd[FLOOR_W-1:0] !== floor_setting) begin
            $error("variance_floor expected %0d actual %0d", floor_setting, rd[FLOOR_W-1:0]);
            failures++;
        end
        apb_write(FLOOR_ADDR, {PAD_W'($urandom_range(0, 65535)), value});
        floor_setting = value;
        apb_read(FLOOR_ADDR, rd);
        if (rd[FLOOR_W-1:0] !== floor_setting) begin
            $error("variance_floor expected %0d actual %0d", floor_setting, rd[FLOOR_W-1:0]);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'd1);
        send_item(CMD_QUERY,      10'd1023, 8'd0,   24'd0);
        send_item(CMD_ACCUMULATE, 10'd0,    8'd255, 24'd0);
        send_item(CMD_ACCUMULATE, 10'd0,    8'd255, 24'd0);
        send_item(CMD_ACCUMULATE, 10'd0,    8'd0,   24'd0);
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'd3);
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'd1);
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'hFFFFFF);
        send_item(CMD_ACCUMULATE, 10'd1023, 8'd1,   24'd0);
        send_item(CMD_ACCUMULATE, 10'd1023, 8'd128, 24'd0);
        send_item(CMD_QUERY,      10'd1023, 8'd0,   24'd2);
        send_item(CMD_UNUSED,     10'd1023, 8'd255, 24'hFFFFFF);
        send_item(CMD_QUERY,      10'd1023, 8'd0,   24'hAAAAAA);
        send_item(CMD_ACCUMULATE, 10'h155,  8'hAA,  24'h555555);
        send_item(CMD_ACCUMULATE, 10'h2AA,  8'h55,  24'h000000);
        send_item(CMD_QUERY,      10'h155,  8'hFF,  24'h555555);
        send_item(CMD_QUERY,      10'h2AA,  8'h00,  24'd1);
        send_item(CMD_CLEAR,      10'h3FF,  8'hFF,  24'hFFFFFF);
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'd3);
        send_item(CMD_QUERY,      10'd1023, 8'd0,   24'd2);
        send_item(CMD_ACCUMULATE, 10'd0,    8'd7,   24'd0);
        send_item(CMD_QUERY,      10'd0,    8'd0,   24'd1);
    endtask

    task automatic random_query(input logic [IDX_W-1:0] idx);
        int pick;
        logic [CNT_W-1:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 55) cnt = CNT_W'(samples_at[idx]);
        else if (pick < 70) cnt = CNT_W'($urandom_range(1, samples_at[idx] + 3));
        else if (pick < 85) cnt = CNT_W'($urandom);
        else if (pick < 92) cnt = '0;
        else cnt = $urandom_range(0, 1) ? {CNT_W{1'b1}} : CNT_W'(1);
        send_item(CMD_QUERY, idx, VAL_W'($urandom), cnt);
    endtask

    task automatic test_random_phase(input int src_pct, input int sink_pct,
                                     input logic [FLOOR_W-1:0] floor_value, input int count);
        int issued;
        int pick;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] base;
        bit cleared;
        settle();
        program_floor(floor_value);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < HOT_COUNT; i++) hot_idx[i] = IDX_W'($urandom);
        base    = VAL_W'($urandom);
        issued  = 0;
        cleared = 0;
        while (issued < count) begin
            pick = $urandom_range(0, 199);
            idx  = ($urandom_range(0, 99) < 80) ? hot_idx[$urandom_range(0, HOT_COUNT - 1)]
                                                 : IDX_W'($urandom);
            if (pick < 4) begin
                send_item(CMD_UNUSED, IDX_W'($urandom), VAL_W'($urandom), CNT_W'($urandom));
            end else if (pick == 4 && !cleared) begin
                cleared = 1;
                send_item(CMD_CLEAR, IDX_W'($urandom), VAL_W'($urandom), CNT_W'($urandom));
                issued++;
            end else if (pick < 114) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) val = VAL_W'($urandom);
                else if (pick < 85) val = base + VAL_W'($urandom_range(0, 3));
                else val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                send_item(CMD_ACCUMULATE, idx, val, CNT_W'($urandom));
                issued++;
            end else begin
                random_query(idx);
                issued++;
            end
        end
    endtask

    task automatic test_output_stall();
        settle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request <= hold_request + 1;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 0) send_item(CMD_ACCUMULATE, hot_idx[i % HOT_COUNT],
                                      VAL_W'($urandom), '0);
            else random_query(hot_idx[i % HOT_COUNT]);
        end
    endtask

    task automatic test_drain_pause();
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        for (int i = 0; i < 10; i++) random_query(hot_idx[i % HOT_COUNT]);
        drain_results();
        for (int i = 0; i < 10; i++) begin
            send_item(CMD_ACCUMULATE, hot_idx[i % HOT_COUNT], VAL_W'($urandom), '0);
            random_query(hot_idx[i % HOT_COUNT]);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = CMD_CLEAR;
        cmd_bus.feature_index = '0;
        cmd_bus.sample_value  = '0;
        cmd_bus.sample_count  = '0;
        res_bus.ready         = 1'b0;
        src_idle_pct          = 0;
        sink_idle_pct         = 0;
        hold_request          = 0;
        hold_served           = 0;
        hold_left             = 0;
        failures              = 0;
        quiet_cycles          = 0;
        floor_setting         = FLOOR_RESET;
        for (int i = 0; i < DEF_FEATURES; i++) begin
            value_sum[i]  = '0;
            square_sum[i] = '0;
            samples_at[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_floor('0);
        test_directed();
        test_random_phase(34, 78, {FLOOR_W{1'b1}}, 280);
        test_random_phase(78, 34, FLOOR_W'($urandom), 280);
        test_random_phase(0, 0, FLOOR_RESET, 250);
        test_output_stall();
        test_drain_pause();

        drain_results();
        repeat (CLEAR_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_stats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
